[rtl/ola_pkg.sv]
// Package for the overlap layer assigner: grid bounds, rectangle type,
// overlap test and the controller state type. No dependencies.
`timescale 1ns / 1ps
package ola_pkg;
   localparam int DEF_MAX_ROWS    = 8;
   localparam int DEF_MAX_COLUMNS = 8;

   typedef struct packed {
      logic [15:0] h;
      logic [15:0] w;
      logic [15:0] y;
      logic [15:0] x;
   } rect_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_RESULT
   } state_type;

   // True when the two rectangles overlap on both axes (strict comparisons).
   function automatic logic rect_overlap(rect_type a, rect_type b);
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic [16:0] adx;
      logic [16:0] ady;
      logic [17:0] sw;
      logic [17:0] sh;
      dx  = {a.x[15], a.x} - {b.x[15], b.x};
      dy  = {a.y[15], a.y} - {b.y[15], b.y};
      adx = dx[16] ? 17'(-dx) : 17'(dx);
      ady = dy[16] ? 17'(-dy) : 17'(dy);
      sw  = {2'b00, a.w} + {2'b00, b.w};
      sh  = {2'b00, a.h} + {2'b00, b.h};
      return ({adx, 1'b0} < sw) && ({ady, 1'b0} < sh);
   endfunction
endpackage

[rtl/ola_cell.sv]
// One cell of the placement chain: holds one grid entry and passes its
// entry to the neighbour when the chain rotates. Depends on ola_pkg.
`timescale 1ns / 1ps
module ola_cell
   import ola_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     clear,
   input  logic     shift,
   input  logic     load,
   input  rect_type load_rect,
   input  logic     prev_valid,
   input  rect_type prev_rect,
   output logic     valid,
   output rect_type rect
);
   logic     valid_ff, valid_in;
   rect_type rect_ff, rect_in;

   always_comb begin
      valid_in = valid_ff;
      rect_in  = rect_ff;
      if (clear) begin
         valid_in = 1'b0;
      end else if (load) begin
         valid_in = 1'b1;
         rect_in  = load_rect;
      end else if (shift) begin
         valid_in = prev_valid;
         rect_in  = prev_rect;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rect_ff <= rect_in;
   end

   assign valid = valid_ff;
   assign rect  = rect_ff;
endmodule

[rtl/ola_chain.sv]
// Ring of grid cells rotating one position per cycle while shift is set;
// cell 0 is the head read by the controller. Depends on ola_pkg and ola_cell.
`timescale 1ns / 1ps
module ola_chain
   import ola_pkg::*;
#(
   parameter int CELLS = DEF_MAX_ROWS * DEF_MAX_COLUMNS
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     clear,
   input  logic     shift,
   input  logic     load,
   input  rect_type load_rect,
   output logic     head_valid,
   output rect_type head_rect
);
   logic     valid [CELLS];
   rect_type rects [CELLS];

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      localparam int PREV = (i + 1) % CELLS;
      ola_cell u_cell (
         .clock(clock), .reset(reset), .clear(clear), .shift(shift),
         .load(load && (i == 0)), .load_rect(load_rect),
         .prev_valid(valid[PREV]), .prev_rect(rects[PREV]),
         .valid(valid[i]), .rect(rects[i])
      );
   end

   assign head_valid = valid[0];
   assign head_rect  = rects[0];
endmodule

[rtl/overlap_layer_assigner_top.sv]
// Top level of the overlap layer assigner: controller, scan position and
// result registers around the cell ring. Depends on ola_pkg and ola_chain.
`timescale 1ns / 1ps
// The grid lives in a ring of MAX_ROWS*MAX_COLUMNS cells that rotates by one
// cell per clock while it is shifted, so the controller sees every entry at
// the ring head in row-major order. An item is scanned in one full turn of
// the ring, followed by a placement state and a result state, whatever the
// grid holds. When the rectangle is stored, the ring then makes a second
// full turn to write it, longer than the scan because the ring pauses while
// the target cell is loaded; busy stays high until that turn ends, and only
// then can the next item be accepted. An item that meets a full grid stores
// nothing and frees the block after the result state. One item is handled
// at a time. The result is shown on the rsp_ ports for exactly one cycle
// with rsp_valid high; the receiver cannot stall it and must take it then.
// Setting req_start_new empties the grid before the item is placed.
module overlap_layer_assigner_top
   import ola_pkg::*;
#(
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_start_new,
   input  logic [15:0] req_centre_x,
   input  logic [15:0] req_centre_y,
   input  logic [15:0] req_rect_width,
   input  logic [15:0] req_rect_height,
   input  logic        req_last_shape,
   output logic        rsp_valid,
   output logic [2:0]  rsp_placed_row,
   output logic [2:0]  rsp_placed_column,
   output logic        rsp_overflow,
   output logic [3:0]  rsp_rows_used,
   output logic [3:0]  rsp_columns_used,
   output logic        rsp_set_done
);
   localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLUMNS + 1);
   localparam int IW    = $clog2(CELLS + 1);

   state_type state_ff, state_in;
   logic [IW-1:0] pos_ff, pos_in;        // ring cycles elapsed this pass
   logic [RW-1:0] srow_ff, srow_in;      // row of the entry at the head
   logic [CW-1:0] scol_ff, scol_in;      // column of the entry at the head
   logic [RW-1:0] rows_ff, rows_in;
   logic [CW-1:0] cols_ff, cols_in;
   logic [RW-1:0] trow_ff, trow_in;      // target row
   logic [CW-1:0] tcol_ff, tcol_in;      // target column
   logic          found_ff, found_in;    // scan decided a target
   logic          hit_ff, hit_in;        // current row overlaps
   rect_type      rect_ff;
   logic          last_ff;
   logic          out_ovf_ff;
   logic [2:0]    out_row_ff, out_col_ff;

   logic          accept;
   logic          clear, shift, load;
   logic          head_valid;
   rect_type      head_rect;
   logic [RW-1:0] scan_row;
   logic [CW-1:0] scan_col;
   logic          ovf;

   assign accept = start && !busy;
   assign scan_row = srow_ff;
   assign scan_col = scol_ff;
   assign ovf = (32'(trow_ff) >= 32'(MAX_ROWS)) || (32'(tcol_ff) >= 32'(MAX_COLUMNS));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_SCAN;
         ST_SCAN:   if (pos_ff == IW'(CELLS - 1)) state_in = ST_PLACE;
         ST_PLACE:  state_in = ST_RESULT;
         ST_RESULT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Chain control and scan bookkeeping. During the scan the ring turns by
   // one cell each cycle; after a full turn cell 0 again holds entry 0. The
   // target is only decided here; the write happens in a later turn.
   always_comb begin
      clear    = accept && req_start_new;
      shift    = (state_ff == ST_SCAN);
      pos_in   = pos_ff;
      srow_in  = srow_ff;
      scol_in  = scol_ff;
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      trow_in  = trow_ff;
      tcol_in  = tcol_ff;
      found_in = found_ff;
      hit_in   = hit_ff;
      load     = 1'b0;
      if (accept) begin
         pos_in   = '0;
         srow_in  = '0;
         scol_in  = '0;
         found_in = 1'b0;
         hit_in   = 1'b0;
         trow_in  = '0;
         tcol_in  = '0;
         if (req_start_new) begin
            rows_in = '0;
            cols_in = '0;
         end
      end else if (state_ff == ST_SCAN) begin
         pos_in = pos_ff + IW'(1);
         if (scol_ff == CW'(MAX_COLUMNS - 1)) begin
            scol_in = '0;
            srow_in = srow_ff + RW'(1);
         end else begin
            scol_in = scol_ff + CW'(1);
         end
         if (!found_ff && (32'(scan_row) < 32'(rows_ff))
             && (32'(scan_col) < 32'(cols_ff))) begin
            if (scan_col == '0) hit_in = 1'b0;
            if (!(hit_ff && scan_col != '0)) begin
               if (!head_valid) begin
                  found_in = 1'b1;
                  trow_in  = scan_row;
                  tcol_in  = scan_col;
               end else if (rect_overlap(rect_ff, head_rect)) begin
                  hit_in  = 1'b1;
                  trow_in = scan_row + RW'(1);
                  tcol_in = '0;
               end else if (scan_col == cols_ff - CW'(1)) begin
                  found_in = 1'b1;
                  trow_in  = scan_row;
                  tcol_in  = cols_ff;
               end
            end
         end
      end else if (state_ff == ST_PLACE) begin
         if (!ovf) begin
            if (trow_ff == rows_ff) rows_in = rows_ff + RW'(1);
            if (tcol_ff == cols_ff) cols_in = cols_ff + CW'(1);
         end
      end
   end

   // Only cell 0 can be loaded, so the target index is latched at the end
   // of the scan and the writer below turns the ring until it arrives.
   logic          wr_pending_ff, wr_pending_in;
   logic [IW-1:0] wr_idx_ff, wr_idx_in;
   logic [IW-1:0] wcnt_ff, wcnt_in;
   logic          wshift;

   // Writer: after the scan the ring turns once more, loading the item at
   // the head when the target entry arrives. The ring does not turn while
   // the item is loaded, so the pass takes a full turn plus the load.
   always_comb begin
      wr_pending_in = wr_pending_ff;
      wr_idx_in     = wr_idx_ff;
      wcnt_in       = wcnt_ff;
      wshift        = 1'b0;
      if (state_ff == ST_PLACE && !ovf) begin
         wr_pending_in = 1'b1;
         wr_idx_in     = IW'(32'(trow_ff) * MAX_COLUMNS + 32'(tcol_ff));
         wcnt_in       = '0;
      end else if (wr_pending_ff) begin
         wshift  = 1'b1;
         wcnt_in = wcnt_ff + IW'(1);
         if (wcnt_ff == IW'(CELLS)) wr_pending_in = 1'b0;
      end
   end

   logic wload;
   assign wload = wr_pending_ff && (wcnt_ff == wr_idx_ff);

   ola_chain #(.CELLS(CELLS)) u_chain (
      .clock(clock), .reset(reset), .clear(clear),
      .shift((shift || wshift) && !wload), .load(load || wload),
      .load_rect(rect_ff), .head_valid(head_valid), .head_rect(head_rect)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         srow_ff       <= '0;
         scol_ff       <= '0;
         rows_ff       <= '0;
         cols_ff       <= '0;
         found_ff      <= 1'b0;
         hit_ff        <= 1'b0;
         wr_pending_ff <= 1'b0;
         wcnt_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         srow_ff       <= srow_in;
         scol_ff       <= scol_in;
         rows_ff       <= rows_in;
         cols_ff       <= cols_in;
         found_ff      <= found_in;
         hit_ff        <= hit_in;
         wr_pending_ff <= wr_pending_in;
         wcnt_ff       <= wcnt_in;
      end
      trow_ff   <= trow_in;
      tcol_ff   <= tcol_in;
      wr_idx_ff <= wr_idx_in;
      if (accept) begin
         rect_ff <= '{h: req_rect_height, w: req_rect_width,
                      y: req_centre_y, x: req_centre_x};
         last_ff <= req_last_shape;
      end
      if (state_ff == ST_PLACE) begin
         out_ovf_ff <= ovf;
         out_row_ff <= ovf ? 3'd0 : 3'(trow_ff);
         out_col_ff <= ovf ? 3'd0 : 3'(tcol_ff);
      end
   end

   // A load holds the ring, so the head entry is written in place; the
   // remaining turn then brings entry 0 back to the head.

   // Outputs.
   always_comb begin
      busy              = (state_ff != ST_IDLE) || wr_pending_ff;
      rsp_valid         = (state_ff == ST_RESULT);
      rsp_placed_row    = out_row_ff;
      rsp_placed_column = out_col_ff;
      rsp_overflow      = out_ovf_ff;
      rsp_rows_used     = 4'(rows_ff);
      rsp_columns_used  = 4'(cols_ff);
      rsp_set_done      = last_ff;
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !(state_ff == ST_IDLE && !wr_pending_ff))
      else $error("busy without work");
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result shown twice");
   a_rows_bound: assert property (@(posedge clock) disable iff (reset)
      32'(rows_ff) <= MAX_ROWS && 32'(cols_ff) <= MAX_COLUMNS)
      else $error("grid count out of bound");
endmodule
